@@ rtl/core/eba_pkg.sv @@
package eba_pkg;

    localparam int MAX_EXTENTS_DEF = 64;

    // Operation codes carried on s_tuser
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOSPACE = 2'd1,
        STAT_DOUBLE  = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    // One free extent held by a cell
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] len;
    } ext_t;

    // Controller status seen by the top level
    typedef struct packed {
        logic busy;
        logic ins_mode;
        logic rem_mode;
    } eba_stat_t;

    // Clamp a widened length sum to 32 bits
    function automatic logic [31:0] sat32(input logic [33:0] v);
        logic [31:0] r;
        r = (v[33:32] != 2'b00) ? 32'hFFFF_FFFF : v[31:0];
        return r;
    endfunction

endpackage

@@ rtl/core/eba_cell.sv @@
module eba_cell (
    input  logic          clk,
    input  logic          shift_en,
    input  eba_pkg::ext_t d,
    output eba_pkg::ext_t q
);
    import eba_pkg::*;

    ext_t q_reg;

    // Take the neighbor's extent on every ring step
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

@@ rtl/core/eba_ctrl.sv @@
module eba_ctrl #(
    parameter int MAX_EXTENTS = eba_pkg::MAX_EXTENTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,
    output logic [1:0]        m_tuser,
    input  eba_pkg::ext_t     head,
    input  eba_pkg::ext_t     nxt,
    output logic              shift_en,
    output eba_pkg::ext_t     tail,
    output eba_pkg::eba_stat_t stat
);
    import eba_pkg::*;

    localparam int IDX_W = $clog2(MAX_EXTENTS);
    localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_EXTENTS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_EXTENTS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_WAIT = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [31:0]       top_reg, top_next;
    logic              grow_dis_reg;
    logic              func_reg, func_next;
    logic              nop_reg, nop_next;
    logic              done_reg, done_next;
    logic              ins_reg, ins_next;
    logic              rem_reg, rem_next;
    logic              setnext_reg, setnext_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       blk_reg, blk_next;
    logic [15:0]       num_reg, num_next;
    logic [32:0]       fend_reg, fend_next;
    ext_t              carry_reg, carry_next;
    logic [31:0]       res_reg, res_next;
    status_t           st_reg, st_next;
    logic [31:0]       out_res_reg, out_res_next;
    status_t           out_st_reg, out_st_next;

    // Step decode
    logic              kv, n_valid, is_first, head_lt_b, nxt_ge_b;
    logic              prev_bnd, zero_bnd;
    logic [32:0]       pend, nb_start33;
    logic              nb_valid, dbl_p, dbl_n, jp, jn;
    logic [33:0]       sum_hc, sum_hcn;
    logic              fit;
    logic [31:0]       newlen, res_alloc;
    ext_t              new_ext, step_tail;
    logic [31:0]       fin_res;
    status_t           fin_st;
    logic              fin_grow;
    logic              out_free;

    assign kv        = CNT_W'(idx_reg) < cnt_reg;
    assign n_valid   = (CNT_W'(idx_reg) + CNT_W'(1)) < cnt_reg;
    assign is_first  = idx_reg == '0;
    assign head_lt_b = head.start < blk_reg;
    assign nxt_ge_b  = nxt.start >= blk_reg;

    // Head is the last extent below block_id
    assign prev_bnd  = kv && head_lt_b && (!n_valid || nxt_ge_b);
    // No extent below block_id: head is the following one
    assign zero_bnd  = is_first && (!kv || !head_lt_b);

    assign pend       = {1'b0, head.start} + {1'b0, head.len};
    assign nb_start33 = {1'b0, (prev_bnd ? nxt.start : head.start)};
    assign nb_valid   = prev_bnd ? n_valid : kv;
    assign dbl_p      = prev_bnd && (pend > {1'b0, blk_reg});
    assign jp         = prev_bnd && (pend == {1'b0, blk_reg});
    assign dbl_n      = nb_valid && (nb_start33 < fend_reg);
    assign jn         = nb_valid && (nb_start33 == fend_reg);

    assign sum_hc  = {2'b00, head.len} + {18'd0, num_reg};
    assign sum_hcn = sum_hc + {2'b00, nxt.len};

    assign fit       = kv && (head.len >= {16'd0, num_reg});
    assign newlen    = head.len - {16'd0, num_reg};
    assign res_alloc = head.start + newlen;

    assign new_ext = '{start: blk_reg, len: {16'd0, num_reg}};

    // One ring step: choose what enters the tail cell
    always_comb
    begin
        step_tail    = head;
        carry_next   = head;
        ins_next     = ins_reg;
        rem_next     = rem_reg;
        setnext_next = 1'b0;
        done_next    = done_reg;
        cnt_next     = cnt_reg;
        res_next     = res_reg;
        st_next      = st_reg;
        if (rem_reg)
        begin
            step_tail = nxt;
        end
        else if (ins_reg)
        begin
            step_tail = carry_reg;
        end
        else if (setnext_reg)
        begin
            step_tail = '{start: blk_reg, len: sat32(sum_hc)};
        end
        else if (!done_reg && !nop_reg)
        begin
            if (func_reg == FUNC_ALLOC)
            begin
                if (fit)
                begin
                    done_next = 1'b1;
                    res_next  = res_alloc;
                    if (newlen == 32'd0)
                    begin
                        step_tail = nxt;
                        rem_next  = 1'b1;
                        cnt_next  = CNT_W'(cnt_reg - 1'b1);
                    end
                    else
                    begin
                        step_tail.len = newlen;
                    end
                end
            end
            else if (func_reg == FUNC_FREE && (prev_bnd || zero_bnd))
            begin
                done_next = 1'b1;
                if (dbl_p || dbl_n)
                begin
                    st_next = STAT_DOUBLE;
                end
                else if (jp && jn)
                begin
                    step_tail.len = sat32(sum_hcn);
                    rem_next      = 1'b1;
                    cnt_next      = CNT_W'(cnt_reg - 1'b1);
                end
                else if (jp)
                begin
                    step_tail.len = sat32(sum_hc);
                end
                else if (jn)
                begin
                    if (prev_bnd)
                    begin
                        setnext_next = 1'b1;
                    end
                    else
                    begin
                        step_tail = '{start: blk_reg, len: sat32(sum_hc)};
                    end
                end
                else if (cnt_reg == FULL_CNT)
                begin
                    st_next = STAT_FULL;
                end
                else
                begin
                    cnt_next = CNT_W'(cnt_reg + 1'b1);
                    ins_next = 1'b1;
                    if (prev_bnd)
                    begin
                        carry_next = new_ext;
                    end
                    else
                    begin
                        step_tail = new_ext;
                    end
                end
            end
        end
    end

    // Final answer at the end of the walk
    always_comb
    begin
        fin_res  = 32'd0;
        fin_st   = st_next;
        fin_grow = 1'b0;
        if (func_reg == FUNC_ALLOC && !nop_reg)
        begin
            if (done_next)
            begin
                fin_res = res_next;
            end
            else if (grow_dis_reg)
            begin
                fin_st = STAT_NOSPACE;
            end
            else
            begin
                fin_res  = top_reg;
                fin_grow = 1'b1;
            end
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        top_next       = top_reg;
        func_next      = func_reg;
        nop_next       = nop_reg;
        blk_next       = blk_reg;
        num_next       = num_reg;
        fend_next      = fend_reg;
        out_res_next   = out_res_reg;
        out_st_next    = out_st_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next  = s_tuser;
                    blk_next   = s_tdata[31:0];
                    num_next   = s_tdata[47:32];
                    fend_next  = {1'b0, s_tdata[31:0]} + {17'd0, s_tdata[47:32]};
                    nop_next   = s_tdata[47:32] == 16'd0;
                    idx_next   = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                idx_next = IDX_W'(idx_reg + 1'b1);
                if (idx_reg == LAST_IDX)
                begin
                    if (fin_grow)
                    begin
                        top_next = top_reg + {16'd0, num_reg};
                    end
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    out_res_next   = res_reg;
                    out_st_next    = st_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            top_reg       <= 32'd0;
            grow_dis_reg  <= 1'b0;
            func_reg      <= FUNC_ALLOC;
            nop_reg       <= 1'b0;
            done_reg      <= 1'b0;
            ins_reg       <= 1'b0;
            rem_reg       <= 1'b0;
            setnext_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            top_reg       <= top_next;
            func_reg      <= func_next;
            nop_reg       <= nop_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                grow_dis_reg <= cfg_wdata;
            end
            if (state_reg == S_IDLE)
            begin
                done_reg    <= 1'b0;
                ins_reg     <= 1'b0;
                rem_reg     <= 1'b0;
                setnext_reg <= 1'b0;
            end
            else if (state_reg == S_RUN)
            begin
                done_reg    <= done_next;
                ins_reg     <= ins_next;
                rem_reg     <= rem_next;
                setnext_reg <= setnext_next;
                cnt_reg     <= cnt_next;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        blk_reg     <= blk_next;
        num_reg     <= num_next;
        fend_reg    <= fend_next;
        out_res_reg <= out_res_next;
        out_st_reg  <= out_st_next;
        if (state_reg == S_IDLE)
        begin
            res_reg <= 32'd0;
            st_reg  <= STAT_OK;
        end
        else if (state_reg == S_RUN)
        begin
            carry_reg <= carry_next;
            if (idx_reg == LAST_IDX)
            begin
                res_reg <= fin_res;
                st_reg  <= fin_st;
            end
            else
            begin
                res_reg <= res_next;
                st_reg  <= st_next;
            end
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg;
    assign m_tuser  = out_st_reg;
    assign shift_en = state_reg == S_RUN;
    assign tail     = step_tail;

    assign stat.busy     = state_reg == S_RUN;
    assign stat.ins_mode = ins_reg;
    assign stat.rem_mode = rem_reg;

endmodule

@@ rtl/core/extent_block_allocator_unit.sv @@
// Each accepted request makes one full turn of the extent ring, which steps one cell per
// cycle, and its result transaction is registered at the end of the turn. A new request
// is taken only once the previous result has been handed to the result register.
// Reset (rst_n, asynchronous, active low): table empty, top pointer zero, growth enabled,
// no result pending. Extent cells hold no reset value and are never read before written.
module extent_block_allocator_unit #(
    parameter int MAX_EXTENTS = eba_pkg::MAX_EXTENTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // growth_disabled register
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    // request side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] block_id, [47:32] count
    input  logic        s_tuser,   // [0] func
    // result side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result_id
    output logic [1:0]  m_tuser    // [1:0] status
);
    import eba_pkg::*;

    // The free extents live in a ring of cells sorted by start, index 0 at the head.
    // A request turns the ring once: each cycle the head leaves cell 0 and the
    // controller pushes a (possibly edited) extent into the last cell. To drop an
    // extent, feed the tail from cell 1 for the rest of the turn; to insert one,
    // push the new extent and pass each later head through a carry register.
    ext_t      cell_q [MAX_EXTENTS];
    ext_t      tail;
    logic      shift_en;
    eba_stat_t stat;

    eba_ctrl #(
        .MAX_EXTENTS(MAX_EXTENTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .head     (cell_q[0]),
        .nxt      (cell_q[1]),
        .shift_en (shift_en),
        .tail     (tail),
        .stat     (stat)
    );

    // Chain of cells: each advances toward the head while the ring turns
    for (genvar i = 0; i < MAX_EXTENTS; i++)
    begin : g_cell
        if (i == MAX_EXTENTS - 1)
        begin : g_last
            eba_cell u_cell (
                .clk     (clk),
                .shift_en(shift_en),
                .d       (tail),
                .q       (cell_q[i])
            );
        end
        else
        begin : g_mid
            eba_cell u_cell (
                .clk     (clk),
                .shift_en(shift_en),
                .d       (cell_q[i+1]),
                .q       (cell_q[i])
            );
        end
    end

    // An accepted transaction starts a ring turn
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> stat.busy)
        else $error("ring turn did not start after request");

    // Drop and insert never share one turn
    a_one_edit: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.ins_mode && stat.rem_mode))
        else $error("insert and remove active together");

    // No request is taken while the ring is turning
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> !s_tready)
        else $error("request accepted during ring turn");

endmodule
